// ----- rtl/core/gqtl_pkg.sv -----
package gqtl_pkg;

  localparam int unsigned CODE_BITS_DFLT  = 8;
  localparam int unsigned COORD_BITS_DFLT = 16;
  localparam int unsigned CODE_MAX_BITS   = 8;
  localparam int unsigned COORD_MAX_BITS  = 24;
  localparam int unsigned CFG_IDX_BITS    = 4;
  localparam int unsigned CFG_DATA_BITS   = 16;
  localparam int unsigned WDATA_BITS      = 40;
  localparam int unsigned CMD_Q_DEPTH     = 2;
  localparam int unsigned RES_Q_DEPTH     = 2;

  localparam logic KIND_VERTEX  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    CMD_METRIC = 2'd0,
    CMD_CORNER = 2'd1,
    CMD_KERN   = 2'd2,
    CMD_LAYOUT = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ORIGIN_X      = 4'd0,
    CFG_ORIGIN_Y      = 4'd1,
    CFG_EXTRA_SPACING = 4'd2,
    CFG_GLYPH_LIMIT   = 4'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_KERN,
    B_PLACE,
    B_UPD
  } b_state_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [7:0]        char_code;
    logic [7:0]        pair_code;
    logic [1:0]        corner;
    logic [7:0]        glyph_width;
    logic [7:0]        glyph_height;
    logic signed [7:0] offset_x;
    logic signed [7:0] offset_y;
    logic signed [7:0] advance;
    logic signed [7:0] kern_amount;
    logic [31:0]       tex_uv;
    logic              end_of_text;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0]        vertex_uv;
    logic [15:0]        glyphs_drawn;
    logic signed [15:0] box_min_x;
    logic signed [15:0] box_min_y;
    logic signed [15:0] box_max_x;
    logic signed [15:0] box_max_y;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic signed [7:0]  extra_spacing;
    logic [15:0]        glyph_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0]        w;
    logic [7:0]        h;
    logic signed [7:0] ox;
    logic signed [7:0] oy;
    logic signed [7:0] adv;
  } metric_t;

  // classified command between front and back
  typedef struct packed {
    cmd_e                    op;
    logic [CODE_MAX_BITS-1:0] code;
    logic [CODE_MAX_BITS-1:0] pair;
    logic [1:0]              corner;
    logic [WDATA_BITS-1:0]   wdata;
    logic                    eot;
  } cmd_item_t;

  // one laid-out character handed to the emitter
  typedef struct packed {
    logic                             has_quad;
    logic                             has_sum;
    logic signed [COORD_MAX_BITS-1:0] x0;
    logic signed [COORD_MAX_BITS-1:0] y0;
    logic signed [COORD_MAX_BITS-1:0] x1;
    logic signed [COORD_MAX_BITS-1:0] y1;
    logic [3:0][31:0]                 uv;
    logic [15:0]                      count;
    logic signed [COORD_MAX_BITS-1:0] bmin_x;
    logic signed [COORD_MAX_BITS-1:0] bmin_y;
    logic signed [COORD_MAX_BITS-1:0] bmax_x;
    logic signed [COORD_MAX_BITS-1:0] bmax_y;
  } job_t;

  localparam logic signed [COORD_MAX_BITS-1:0] S16_MAX = COORD_MAX_BITS'(32767);
  localparam logic signed [COORD_MAX_BITS-1:0] S16_MIN = ~S16_MAX;

  function automatic logic signed [15:0] sat16(input logic signed [COORD_MAX_BITS-1:0] v);
    logic signed [COORD_MAX_BITS-1:0] r;
    if (v > S16_MAX) begin
      r = S16_MAX;
    end else if (v < S16_MIN) begin
      r = S16_MIN;
    end else begin
      r = v;
    end
    return r[15:0];
  endfunction

endpackage

// ----- rtl/core/gqtl_fifo.sv -----
module gqtl_fifo import gqtl_pkg::*; #(
  parameter type         item_t = logic,
  parameter int unsigned DEPTH  = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t data_o,
  output logic  empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t          mem [DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  cnt_q;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem[rd_ptr_q];

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wrap_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= wrap_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/gqtl_front.sv -----
module gqtl_front import gqtl_pkg::*; #(
  parameter int unsigned CODE_BITS = CODE_BITS_DFLT
) (
  input  logic      push_i,
  input  in_item_t  in_item_i,
  output logic      full_o,
  input  logic      clearing_i,
  input  logic      q_full_i,
  output logic      q_push_o,
  output cmd_item_t q_item_o
);

  metric_t m;

  assign full_o   = q_full_i || clearing_i;
  assign q_push_o = push_i && !full_o;

  always_comb begin
    m.w   = in_item_i.glyph_width;
    m.h   = in_item_i.glyph_height;
    m.ox  = in_item_i.offset_x;
    m.oy  = in_item_i.offset_y;
    m.adv = in_item_i.advance;

    q_item_o.op     = cmd_e'(in_item_i.cmd);
    q_item_o.code   = CODE_MAX_BITS'(in_item_i.char_code[CODE_BITS-1:0]);
    q_item_o.pair   = CODE_MAX_BITS'(in_item_i.pair_code[CODE_BITS-1:0]);
    q_item_o.corner = in_item_i.corner;
    q_item_o.eot    = in_item_i.end_of_text;
    case (cmd_e'(in_item_i.cmd))
      CMD_METRIC: q_item_o.wdata = m;
      CMD_CORNER: q_item_o.wdata = WDATA_BITS'(in_item_i.tex_uv);
      CMD_KERN:   q_item_o.wdata = WDATA_BITS'(unsigned'(in_item_i.kern_amount));
      default:    q_item_o.wdata = '0;
    endcase
  end

endmodule

// ----- rtl/core/gqtl_back.sv -----
module gqtl_back import gqtl_pkg::*; #(
  parameter int unsigned CODE_BITS  = CODE_BITS_DFLT,
  parameter int unsigned COORD_BITS = COORD_BITS_DFLT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  cmd_item_t q_item_i,
  input  logic      q_empty_i,
  output logic      q_pop_o,
  output job_t      job_o,
  output logic      job_valid_o,
  input  logic      job_ready_i,
  output logic      clearing_o
);

  localparam int unsigned NCODES   = 1 << CODE_BITS;
  localparam int unsigned KEY_BITS = 2 * CODE_BITS;
  localparam int unsigned NKEYS    = 1 << KEY_BITS;
  localparam int unsigned WIDE     = ((COORD_BITS > 16) ? COORD_BITS : 16) + 3;
  localparam logic signed [WIDE-1:0] C_MAX = WIDE'((1 << (COORD_BITS - 1)) - 1);
  localparam logic signed [WIDE-1:0] C_MIN = ~C_MAX;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  function automatic coord_t sat_c(input logic signed [WIDE-1:0] v);
    logic signed [WIDE-1:0] r;
    if (v > C_MAX) begin
      r = C_MAX;
    end else if (v < C_MIN) begin
      r = C_MIN;
    end else begin
      r = v;
    end
    return r[COORD_BITS-1:0];
  endfunction

  // tables
  metric_t          metric_mem [NCODES];
  logic [3:0][31:0] corner_mem [NCODES];
  logic [7:0]       kern_mem   [NKEYS];

  metric_t           metric_rd_q;
  logic [3:0][31:0]  corner_rd_q;
  logic signed [7:0] kern_rd_q;

  logic                clearing_q;
  logic [KEY_BITS-1:0] clr_idx_q;
  logic                clr_in_rows;

  logic [CODE_BITS-1:0] code, pair;
  logic                 pop_layout;

  // per-string state
  logic                 prev_valid_q;
  logic [CODE_BITS-1:0] prev_code_q;
  coord_t               pen_x_q;
  logic [15:0]          drawn_q;
  logic                 stopped_q;
  coord_t               bmin_x_q, bmin_y_q, bmax_x_q, bmax_y_q;

  // per-character working registers
  b_state_e state_q, state_d;
  logic     s_first_q, s_eot_q;
  coord_t   pen_k_q, pen_adv_q;
  logic     stop_w_q, draw_q;
  coord_t   x0_q, y0_q, x1_q, y1_q;

  coord_t                 base_pen, pen_k_d;
  logic                   stop_eff;
  logic signed [WIDE-1:0] xo, yo;
  coord_t                 x0_d, y0_d, x1_d, y1_d, pen_adv_d;
  logic [15:0]            cnt_new;
  logic                   stop_new, first_draw;
  coord_t                 pen_new;
  coord_t                 bmin_x_n, bmin_y_n, bmax_x_n, bmax_y_n;

  logic job_need, upd_go, upd_fire, can_take;
  job_t job_q, job_d;
  logic job_valid_q;

  assign clearing_o  = clearing_q;
  assign code        = q_item_i.code[CODE_BITS-1:0];
  assign pair        = q_item_i.pair[CODE_BITS-1:0];
  assign pop_layout  = q_pop_o && (q_item_i.op == CMD_LAYOUT);
  assign clr_in_rows = (clr_idx_q[KEY_BITS-1:CODE_BITS] == '0);

  // clearing pass after reset, one kerning entry and one table row per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clearing_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == '1) begin
        clearing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      kern_mem[clr_idx_q] <= '0;
      if (clr_in_rows) begin
        metric_mem[clr_idx_q[CODE_BITS-1:0]] <= '0;
        corner_mem[clr_idx_q[CODE_BITS-1:0]] <= '0;
      end
    end else if (q_pop_o) begin
      case (q_item_i.op)
        CMD_METRIC: metric_mem[code] <= metric_t'(q_item_i.wdata);
        CMD_CORNER: corner_mem[code][q_item_i.corner] <= q_item_i.wdata[31:0];
        CMD_KERN:   kern_mem[{code, pair}] <= q_item_i.wdata[7:0];
        CMD_LAYOUT: begin
          metric_rd_q <= metric_mem[code];
          corner_rd_q <= corner_mem[code];
          kern_rd_q   <= $signed(kern_mem[{prev_code_q, code}]);
        end
        default: ;
      endcase
    end
  end

  // kerning step
  always_comb begin
    base_pen = s_first_q ? sat_c(WIDE'(cfg_i.origin_x)) : pen_x_q;
    stop_eff = stopped_q || ((cfg_i.glyph_limit != '0) && (drawn_q >= cfg_i.glyph_limit));
    if (!stop_eff && !s_first_q) begin
      pen_k_d = sat_c(WIDE'(base_pen) + WIDE'(kern_rd_q));
    end else begin
      pen_k_d = base_pen;
    end
  end

  // corner placement and advance
  always_comb begin
    xo        = WIDE'(pen_k_q) + WIDE'(metric_rd_q.ox);
    yo        = WIDE'(cfg_i.origin_y) + WIDE'(metric_rd_q.oy);
    x0_d      = sat_c(xo);
    y0_d      = sat_c(yo);
    x1_d      = sat_c(xo + $signed(WIDE'({1'b0, metric_rd_q.w})));
    y1_d      = sat_c(yo + $signed(WIDE'({1'b0, metric_rd_q.h})));
    pen_adv_d = sat_c(WIDE'(pen_k_q) + WIDE'(metric_rd_q.adv) + WIDE'(cfg_i.extra_spacing));
  end

  // string state update
  always_comb begin
    first_draw = (drawn_q == '0);
    cnt_new    = (draw_q && (drawn_q != '1)) ? drawn_q + 1'b1 : drawn_q;
    stop_new   = stop_w_q || ((cfg_i.glyph_limit != '0) && (cnt_new >= cfg_i.glyph_limit));
    pen_new    = stop_new ? pen_k_q : pen_adv_q;
    bmin_x_n   = bmin_x_q;
    bmin_y_n   = bmin_y_q;
    bmax_x_n   = bmax_x_q;
    bmax_y_n   = bmax_y_q;
    if (draw_q) begin
      if (first_draw || (x0_q < bmin_x_q)) bmin_x_n = x0_q;
      if (first_draw || (y0_q < bmin_y_q)) bmin_y_n = y0_q;
      if (first_draw || (x1_q > bmax_x_q)) bmax_x_n = x1_q;
      if (first_draw || (y1_q > bmax_y_q)) bmax_y_n = y1_q;
    end

    job_d.has_quad = draw_q;
    job_d.has_sum  = s_eot_q;
    job_d.x0       = COORD_MAX_BITS'(x0_q);
    job_d.y0       = COORD_MAX_BITS'(y0_q);
    job_d.x1       = COORD_MAX_BITS'(x1_q);
    job_d.y1       = COORD_MAX_BITS'(y1_q);
    job_d.uv       = corner_rd_q;
    job_d.count    = cnt_new;
    job_d.bmin_x   = COORD_MAX_BITS'(bmin_x_n);
    job_d.bmin_y   = COORD_MAX_BITS'(bmin_y_n);
    job_d.bmax_x   = COORD_MAX_BITS'(bmax_x_n);
    job_d.bmax_y   = COORD_MAX_BITS'(bmax_y_n);
  end

  assign job_need = draw_q || s_eot_q;
  assign can_take = !clearing_q && !q_empty_i;
  assign upd_fire = (state_q == B_UPD) && upd_go;

  always_comb begin
    state_d = state_q;
    upd_go  = !job_need || !job_valid_q || job_ready_i;
    q_pop_o = 1'b0;
    case (state_q)
      B_IDLE:  q_pop_o = can_take;
      B_KERN:  state_d = B_PLACE;
      B_PLACE: state_d = B_UPD;
      B_UPD: begin
        if (upd_go) begin
          q_pop_o = can_take;
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
    if (q_pop_o && (q_item_i.op == CMD_LAYOUT)) begin
      state_d = B_KERN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_valid_q <= 1'b0;
      prev_code_q  <= '0;
      pen_x_q      <= '0;
      drawn_q      <= '0;
      stopped_q    <= 1'b0;
      bmin_x_q     <= '0;
      bmin_y_q     <= '0;
      bmax_x_q     <= '0;
      bmax_y_q     <= '0;
    end else begin
      if (pop_layout) begin
        prev_valid_q <= !q_item_i.eot;
        prev_code_q  <= code;
      end
      if (upd_fire) begin
        if (s_eot_q) begin
          pen_x_q   <= '0;
          drawn_q   <= '0;
          stopped_q <= 1'b0;
          bmin_x_q  <= '0;
          bmin_y_q  <= '0;
          bmax_x_q  <= '0;
          bmax_y_q  <= '0;
        end else begin
          pen_x_q   <= pen_new;
          drawn_q   <= cnt_new;
          stopped_q <= stop_new;
          bmin_x_q  <= bmin_x_n;
          bmin_y_q  <= bmin_y_n;
          bmax_x_q  <= bmax_x_n;
          bmax_y_q  <= bmax_y_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_layout) begin
      s_first_q <= !prev_valid_q;
      s_eot_q   <= q_item_i.eot;
    end
    if (state_q == B_KERN) begin
      pen_k_q  <= pen_k_d;
      stop_w_q <= stop_eff;
    end
    if (state_q == B_PLACE) begin
      x0_q      <= x0_d;
      y0_q      <= y0_d;
      x1_q      <= x1_d;
      y1_q      <= y1_d;
      pen_adv_q <= pen_adv_d;
      draw_q    <= !stop_w_q && (metric_rd_q.w != '0);
    end
    if (upd_fire && job_need) begin
      job_q <= job_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
    end else if (upd_fire && job_need) begin
      job_valid_q <= 1'b1;
    end else if (job_ready_i) begin
      job_valid_q <= 1'b0;
    end
  end

  assign job_o       = job_q;
  assign job_valid_o = job_valid_q;

endmodule

// ----- rtl/core/gqtl_emit.sv -----
module gqtl_emit import gqtl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_t      job_i,
  input  logic      job_valid_i,
  output logic      job_ready_o,
  output out_item_t res_o,
  output logic      res_push_o,
  input  logic      res_full_i
);

  localparam logic [2:0] PH_FIRST = 3'd0;
  localparam logic [2:0] PH_LAST_VTX = 3'd3;
  localparam logic [2:0] PH_SUM = 3'd4;

  job_t       cur_q;
  logic       busy_q;
  logic [2:0] phase_q;
  logic       final_step, take;

  assign final_step  = ((phase_q == PH_LAST_VTX) && !cur_q.has_sum) || (phase_q == PH_SUM);
  assign res_push_o  = busy_q && !res_full_i;
  assign job_ready_o = !busy_q || (res_push_o && final_step);
  assign take        = job_valid_i && job_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= PH_FIRST;
    end else if (take) begin
      busy_q  <= 1'b1;
      phase_q <= job_i.has_quad ? PH_FIRST : PH_SUM;
    end else if (res_push_o) begin
      if (final_step) begin
        busy_q <= 1'b0;
      end else begin
        phase_q <= (phase_q == PH_LAST_VTX) ? PH_SUM : phase_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cur_q <= job_i;
    end
  end

  always_comb begin
    res_o      = '0;
    res_o.last = final_step;
    if (phase_q == PH_SUM) begin
      res_o.kind         = KIND_SUMMARY;
      res_o.glyphs_drawn = cur_q.count;
      res_o.box_min_x    = sat16(cur_q.bmin_x);
      res_o.box_min_y    = sat16(cur_q.bmin_y);
      res_o.box_max_x    = sat16(cur_q.bmax_x);
      res_o.box_max_y    = sat16(cur_q.bmax_y);
    end else begin
      // corners: top-left, top-right, bottom-right, bottom-left
      res_o.kind      = KIND_VERTEX;
      res_o.pos_x     = sat16((phase_q[0] ^ phase_q[1]) ? cur_q.x1 : cur_q.x0);
      res_o.pos_y     = sat16(phase_q[1] ? cur_q.y1 : cur_q.y0);
      res_o.vertex_uv = cur_q.uv[phase_q[1:0]];
    end
  end

endmodule

// ----- rtl/core/glyph_quad_text_layout.sv -----
// Channel  | Handshake                     | Payload
// ---------+-------------------------------+---------------------------------
// input    | push / full                   | in_item_i  (in_item_t)
// result   | empty / pop                   | out_item_o (out_item_t)
// config   | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//
// A layout item passes through three steps in the layout engine (kerning add,
// corner placement, state update); its vertices leave one per cycle while the
// result queue is not full, four per drawn glyph, plus a summary at end of text.
// After reset the kerning, metric and corner tables are cleared while full is
// high, one kerning entry a cycle and one table row a cycle until all rows are clear.
// A full result queue stalls the emitter, then the engine, then the input.
module glyph_quad_text_layout import gqtl_pkg::*; #(
  parameter int unsigned CODE_BITS  = CODE_BITS_DFLT,
  parameter int unsigned COORD_BITS = COORD_BITS_DFLT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  in_item_t                 in_item_i,
  output logic                     empty,
  input  logic                     pop,
  output out_item_t                out_item_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  cfg_t      cfg_q;
  logic      clearing;
  logic      q_push, q_full, q_empty, q_pop;
  cmd_item_t q_in, q_out;
  job_t      job;
  logic      job_valid, job_ready;
  out_item_t res;
  logic      res_push, res_full;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ORIGIN_X:      cfg_q.origin_x      <= cfg_data_i;
        CFG_ORIGIN_Y:      cfg_q.origin_y      <= cfg_data_i;
        CFG_EXTRA_SPACING: cfg_q.extra_spacing <= cfg_data_i[7:0];
        CFG_GLYPH_LIMIT:   cfg_q.glyph_limit   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gqtl_front #(
    .CODE_BITS(CODE_BITS)
  ) u_front (
    .push_i     (push),
    .in_item_i  (in_item_i),
    .full_o     (full),
    .clearing_i (clearing),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_in)
  );

  gqtl_fifo #(
    .item_t(cmd_item_t),
    .DEPTH (CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  gqtl_back #(
    .CODE_BITS (CODE_BITS),
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_item_i    (q_out),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .job_o       (job),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .clearing_o  (clearing)
  );

  gqtl_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .res_o       (res),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  gqtl_fifo #(
    .item_t(out_item_t),
    .DEPTH (RES_Q_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(res_push && res_full))
    else $error("result pushed into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) clearing |-> !q_pop)
    else $error("command taken during table clear");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (out_item_o.kind == KIND_SUMMARY)) |-> out_item_o.last)
    else $error("summary without last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid && !job_ready) |=> job_valid)
    else $error("job dropped before emitter took it");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import gqtl_pkg::*;

  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEM_TARGET = 400;
  localparam int MAX_REPORTS = 10;
  localparam int N_ALPHA = 12;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = '1;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_TOP = 8'hFF;

  typedef struct {
    bit                       is_cfg;
    logic [CFG_IDX_BITS-1:0]  idx;
    logic [CFG_DATA_BITS-1:0] data;
    in_item_t                 item;
    bit                       typed;
    out_item_t                want;
  } step_t;

  logic                     clk = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     push = 1'b0;
  logic                     full;
  in_item_t                 in_item = '0;
  logic                     empty;
  logic                     pop = 1'b0;
  out_item_t                out_item;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  metric_t           metrics [256];
  logic [31:0]       corner_uv [1024];
  logic signed [7:0] kern_amt [65536];
  cfg_t              layout_cfg;
  int                pen_x;
  bit                has_prev;
  logic [7:0]        prev_code;
  int                drawn;
  bit                halted;
  int                box [4];

  out_item_t glyph_stream [$];
  out_item_t fresh [$];
  out_item_t empty_summary;
  step_t     plan [$];
  logic [7:0] alphabet [N_ALPHA];

  int errors = 0;
  int n_items = 0;
  int n_layout = 0;
  int n_loads = 0;
  int n_results = 0;
  int n_cfg = 0;
  int n_phases = 0;
  bit hold_req = 1'b0;
  bit gaps_on = 1'b1;
  int burst_left = 4;

  glyph_quad_text_layout dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int clamp16(int v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  function automatic out_item_t vertex(int x, int y, logic [31:0] uv);
    out_item_t r;
    r = '0;
    r.kind = KIND_VERTEX;
    r.pos_x = 16'(x);
    r.pos_y = 16'(y);
    r.vertex_uv = uv;
    return r;
  endfunction

  function automatic void add_row(step_t r);
    plan.insert(plan.size(), r);
  endfunction

  function automatic void restart_string();
    pen_x = clamp16(int'(layout_cfg.origin_x));
    has_prev = 1'b0;
    prev_code = '0;
    drawn = 0;
    halted = 1'b0;
    box = '{default: 0};
  endfunction

  function automatic void clear_tables();
    for (int i = 0; i < 256; i++) metrics[i] = '0;
    for (int i = 0; i < 1024; i++) corner_uv[i] = '0;
    for (int i = 0; i < 65536; i++) kern_amt[i] = '0;
    layout_cfg = '0;
    restart_string();
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_BITS-1:0] idx,
                                    logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      CFG_ORIGIN_X:      layout_cfg.origin_x = data;
      CFG_ORIGIN_Y:      layout_cfg.origin_y = data;
      CFG_EXTRA_SPACING: layout_cfg.extra_spacing = data[7:0];
      CFG_GLYPH_LIMIT:   layout_cfg.glyph_limit = data;
      default: ;
    endcase
  endfunction

  // fills fresh with the vertices and summary one item produces
  function automatic void place_glyph(in_item_t it);
    metric_t   m;
    int        x0, y0, x1, y1;
    int        xs [4];
    int        ys [4];
    out_item_t s;
    fresh.delete();
    case (it.cmd)
      CMD_METRIC: metrics[it.char_code] = {it.glyph_width, it.glyph_height,
                                           it.offset_x, it.offset_y, it.advance};
      CMD_CORNER: corner_uv[{it.char_code, it.corner}] = it.tex_uv;
      CMD_KERN:   kern_amt[{it.char_code, it.pair_code}] = it.kern_amount;
      default: begin
        if (!has_prev) pen_x = clamp16(int'(layout_cfg.origin_x));
        if (layout_cfg.glyph_limit != 0 && drawn >= layout_cfg.glyph_limit) halted = 1'b1;
        if (!halted) begin
          m = metrics[it.char_code];
          if (has_prev) pen_x = clamp16(pen_x + int'(kern_amt[{prev_code, it.char_code}]));
          if (m.w != 0) begin
            x0 = clamp16(pen_x + int'(m.ox));
            y0 = clamp16(int'(layout_cfg.origin_y) + int'(m.oy));
            x1 = clamp16(pen_x + int'(m.ox) + int'(m.w));
            y1 = clamp16(int'(layout_cfg.origin_y) + int'(m.oy) + int'(m.h));
            xs = '{x0, x1, x1, x0};
            ys = '{y0, y0, y1, y1};
            for (int k = 0; k < 4; k++) begin
              fresh.insert(fresh.size(),
                           vertex(xs[k], ys[k], corner_uv[{it.char_code, 2'(k)}]));
            end
            if (drawn == 0) begin
              box = '{x0, y0, x1, y1};
            end else begin
              if (x0 < box[0]) box[0] = x0;
              if (y0 < box[1]) box[1] = y0;
              if (x1 > box[2]) box[2] = x1;
              if (y1 > box[3]) box[3] = y1;
            end
            if (drawn < 65535) drawn++;
            if (layout_cfg.glyph_limit != 0 && drawn >= layout_cfg.glyph_limit) halted = 1'b1;
          end
          if (!halted) begin
            pen_x = clamp16(pen_x + int'(m.adv) + int'(layout_cfg.extra_spacing));
          end
        end
        has_prev = 1'b1;
        prev_code = it.char_code;
        if (it.end_of_text) begin
          s = '0;
          s.kind = KIND_SUMMARY;
          s.glyphs_drawn = 16'(drawn);
          if (drawn != 0) begin
            s.box_min_x = 16'(box[0]);
            s.box_min_y = 16'(box[1]);
            s.box_max_x = 16'(box[2]);
            s.box_max_y = 16'(box[3]);
          end
          s.last = 1'b1;
          fresh.insert(fresh.size(), s);
          restart_string();
        end else if (fresh.size() > 0) begin
          fresh[fresh.size() - 1].last = 1'b1;
        end
      end
    endcase
  endfunction

  function automatic string fmt(out_item_t r);
    return $sformatf("kind=%0d x=%0d y=%0d uv=%h n=%0d box=(%0d,%0d,%0d,%0d) last=%0d",
                     r.kind, r.pos_x, r.pos_y, r.vertex_uv, r.glyphs_drawn,
                     r.box_min_x, r.box_min_y, r.box_max_x, r.box_max_y, r.last);
  endfunction

  function automatic void note_failure(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%s", msg);
  endfunction

  task automatic take_result(input out_item_t got);
    out_item_t want;
    string     diff;
    n_results++;
    if (glyph_stream.size() == 0) begin
      note_failure($sformatf("result %0d with nothing pending: %s", n_results, fmt(got)));
      return;
    end
    want = glyph_stream.pop_front();
    diff = "";
    if (got.kind !== want.kind) diff = {diff, " kind"};
    if (got.pos_x !== want.pos_x) diff = {diff, " pos_x"};
    if (got.pos_y !== want.pos_y) diff = {diff, " pos_y"};
    if (got.vertex_uv !== want.vertex_uv) diff = {diff, " vertex_uv"};
    if (got.glyphs_drawn !== want.glyphs_drawn) diff = {diff, " glyphs_drawn"};
    if (got.box_min_x !== want.box_min_x) diff = {diff, " box_min_x"};
    if (got.box_min_y !== want.box_min_y) diff = {diff, " box_min_y"};
    if (got.box_max_x !== want.box_max_x) diff = {diff, " box_max_x"};
    if (got.box_max_y !== want.box_max_y) diff = {diff, " box_max_y"};
    if (got.last !== want.last) diff = {diff, " last"};
    if (diff != "") begin
      note_failure($sformatf("result %0d wrong in%s\n  exp %s\n  got %s",
                             n_results, diff, fmt(want), fmt(got)));
    end
  endtask

  function automatic in_item_t rand_item();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t mk_metric(logic [7:0] code, int w, int h, int ox, int oy,
                                         int adv);
    in_item_t it;
    it = rand_item();
    it.cmd = CMD_METRIC;
    it.char_code = code;
    it.glyph_width = 8'(w);
    it.glyph_height = 8'(h);
    it.offset_x = 8'(ox);
    it.offset_y = 8'(oy);
    it.advance = 8'(adv);
    return it;
  endfunction

  function automatic in_item_t mk_corner(logic [7:0] code, logic [1:0] corner,
                                         logic [31:0] uv);
    in_item_t it;
    it = rand_item();
    it.cmd = CMD_CORNER;
    it.char_code = code;
    it.corner = corner;
    it.tex_uv = uv;
    return it;
  endfunction

  function automatic in_item_t mk_kern(logic [7:0] code, logic [7:0] pair, int amt);
    in_item_t it;
    it = rand_item();
    it.cmd = CMD_KERN;
    it.char_code = code;
    it.pair_code = pair;
    it.kern_amount = 8'(amt);
    return it;
  endfunction

  function automatic in_item_t mk_char(logic [7:0] code, bit eot);
    in_item_t it;
    it = rand_item();
    it.cmd = CMD_LAYOUT;
    it.char_code = code;
    it.end_of_text = eot;
    return it;
  endfunction

  function automatic step_t item_row(in_item_t it);
    step_t r;
    r.is_cfg = 1'b0;
    r.idx = '0;
    r.data = '0;
    r.item = it;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic step_t typed_row(in_item_t it, out_item_t want);
    step_t r;
    r = item_row(it);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic step_t cfg_row(logic [CFG_IDX_BITS-1:0] idx,
                                    logic [CFG_DATA_BITS-1:0] data);
    step_t r;
    r = item_row('0);
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic logic [7:0] pick_code();
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    return alphabet[$urandom_range(0, N_ALPHA - 1)];
  endfunction

  function automatic in_item_t next_random_item();
    in_item_t it;
    int       r;
    it = rand_item();
    r = $urandom_range(0, 99);
    if (r < 8) begin
      it.cmd = CMD_METRIC;
      it.char_code = pick_code();
      if ($urandom_range(0, 3) == 0) it.glyph_width = '0;
    end else if (r < 14) begin
      it.cmd = CMD_CORNER;
      it.char_code = pick_code();
    end else if (r < 20) begin
      it.cmd = CMD_KERN;
      it.char_code = pick_code();
      it.pair_code = pick_code();
    end else if (r >= 23) begin
      it.cmd = CMD_LAYOUT;
      it.char_code = pick_code();
      it.end_of_text = ($urandom_range(0, 5) == 0);
    end
    return it;
  endfunction

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 3))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(0, 400) - 200);
    endcase
  endfunction

  function automatic logic [15:0] pick_spacing();
    logic [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(0, 3))
      0:       v[7:0] = 8'h7F;
      1:       v[7:0] = 8'h80;
      2:       v[7:0] = 8'($urandom_range(0, 16) - 8);
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 5))
      3:       return 16'($urandom_range(1, 6));
      4:       return 16'hFFFF;
      5:       return 16'($urandom_range(1, 3));
      default: return '0;
    endcase
  endfunction

  task automatic pace();
    int gap;
    if (!gaps_on) return;
    burst_left--;
    if (burst_left > 0) return;
    gap = $urandom_range(1, 8);
    @(negedge clk);
    push = 1'b0;
    repeat (gap - 1) @(negedge clk);
    burst_left = $urandom_range(1, 16);
  endtask

  task automatic offer(input in_item_t it, input bit typed, input out_item_t want);
    @(negedge clk);
    push = 1'b1;
    in_item = it;
    @(posedge clk);
    while (full) @(posedge clk);
    place_glyph(it);
    if (typed) begin
      glyph_stream.insert(glyph_stream.size(), want);
    end else begin
      foreach (fresh[i]) glyph_stream.insert(glyph_stream.size(), fresh[i]);
    end
    n_items++;
    if (it.cmd == CMD_LAYOUT) n_layout++;
    else n_loads++;
    pace();
  endtask

  task automatic drain_wait();
    @(negedge clk);
    push = 1'b0;
    while (glyph_stream.size() != 0) @(posedge clk);
  endtask

  task automatic quiesce();
    drain_wait();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
    n_cfg++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic vary_settings();
    quiesce();
    if ($urandom_range(0, 1)) write_reg(CFG_ORIGIN_X, pick_coord());
    if ($urandom_range(0, 1)) write_reg(CFG_ORIGIN_Y, pick_coord());
    if ($urandom_range(0, 1)) write_reg(CFG_EXTRA_SPACING, pick_spacing());
    if ($urandom_range(0, 1)) write_reg(CFG_GLYPH_LIMIT, pick_limit());
    if ($urandom_range(0, 4) == 0) write_reg(4'($urandom_range(4, 15)), 16'($urandom));
  endtask

  initial begin
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin : drain
    int cyc;
    int mode;
    int period;
    cyc = 0;
    mode = 0;
    period = 3;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        pop = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        cyc++;
        if (cyc % 256 == 0) begin
          mode = $urandom_range(0, 3);
          period = $urandom_range(2, 9);
        end
        case (mode)
          0:       pop = 1'b1;
          1:       pop = 1'($urandom_range(0, 1));
          2:       pop = ((cyc % period) == 0);
          default: pop = ((cyc % period) != 0);
        endcase
        @(posedge clk);
        if (pop && !empty) take_result(out_item);
      end
    end
  end

  initial begin : stim
    in_item_t it;
    int       len;
    clear_tables();
    empty_summary = '0;
    empty_summary.kind = KIND_SUMMARY;
    empty_summary.last = 1'b1;

    add_row(typed_row(mk_char(CH_NUL, 1'b1), empty_summary));
    add_row(item_row(mk_metric(CH_A, 10, 12, 1, -12, 11)));
    add_row(item_row(mk_corner(CH_A, 2'd0, 32'h0000_0000)));
    add_row(item_row(mk_corner(CH_A, 2'd1, 32'hFFFF_0000)));
    add_row(item_row(mk_corner(CH_A, 2'd2, 32'hFFFF_FFFF)));
    add_row(item_row(mk_corner(CH_A, 2'd3, 32'h0000_FFFF)));
    add_row(item_row(mk_metric(CH_TOP, 255, 255, 127, 127, 127)));
    add_row(item_row(mk_metric(CH_NUL, 0, 0, -128, -128, -128)));
    add_row(item_row(mk_kern(CH_A, CH_TOP, -128)));
    add_row(item_row(mk_kern(CH_TOP, CH_A, 127)));
    add_row(item_row(mk_char(CH_A, 1'b0)));
    add_row(item_row(mk_char(CH_TOP, 1'b0)));
    add_row(item_row(mk_char(CH_A, 1'b0)));
    add_row(item_row(mk_char(CH_NUL, 1'b1)));
    add_row(cfg_row(CFG_ORIGIN_X, 16'h7FFF));
    add_row(cfg_row(CFG_ORIGIN_Y, 16'h8000));
    add_row(cfg_row(CFG_EXTRA_SPACING, 16'h007F));
    add_row(cfg_row(CFG_GLYPH_LIMIT, 16'd2));
    add_row(item_row(mk_char(CH_TOP, 1'b0)));
    add_row(item_row(mk_char(CH_TOP, 1'b0)));
    add_row(item_row(mk_char(CH_A, 1'b0)));
    add_row(item_row(mk_char(CH_TOP, 1'b1)));
    add_row(cfg_row(CFG_ORIGIN_X, 16'h8000));
    add_row(cfg_row(CFG_ORIGIN_Y, 16'h7FFF));
    add_row(cfg_row(CFG_EXTRA_SPACING, 16'hA580));
    add_row(cfg_row(CFG_GLYPH_LIMIT, 16'd0));
    add_row(cfg_row(CFG_SPARE, 16'hFFFF));
    add_row(item_row(mk_char(CH_A, 1'b0)));
    add_row(item_row(mk_char(CH_NUL, 1'b0)));
    add_row(item_row(mk_char(CH_A, 1'b1)));
    add_row(cfg_row(CFG_GLYPH_LIMIT, 16'd1));
    add_row(typed_row(mk_char(CH_NUL, 1'b1), empty_summary));
    add_row(item_row(mk_char(CH_A, 1'b0)));
    add_row(item_row(mk_char(CH_A, 1'b1)));
    add_row(cfg_row(CFG_GLYPH_LIMIT, 16'hFFFF));
    add_row(cfg_row(CFG_ORIGIN_X, 16'h0000));
    add_row(cfg_row(CFG_ORIGIN_Y, 16'h0000));
    add_row(cfg_row(CFG_EXTRA_SPACING, 16'h0000));
    add_row(item_row(mk_char(CH_A, 1'b0)));
    add_row(item_row(mk_char(CH_A, 1'b0)));
    // limit lowered while a string is open
    add_row(cfg_row(CFG_GLYPH_LIMIT, 16'd1));
    add_row(item_row(mk_char(CH_A, 1'b0)));
    add_row(item_row(mk_char(CH_A, 1'b1)));

    repeat (3) @(negedge clk);
    rst_ni = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        quiesce();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        offer(plan[i].item, plan[i].typed, plan[i].want);
      end
    end

    foreach (alphabet[i]) alphabet[i] = 8'($urandom);
    foreach (alphabet[i]) begin
      it = rand_item();
      it.cmd = CMD_METRIC;
      it.char_code = alphabet[i];
      if (it.glyph_width == 0) it.glyph_width = 8'd1;
      offer(it, 1'b0, '0);
      for (int k = 0; k < 4; k++) offer(mk_corner(alphabet[i], 2'(k), $urandom), 1'b0, '0);
    end
    repeat (16) offer(mk_kern(pick_code(), pick_code(), int'($urandom_range(0, 255)) - 128),
                      1'b0, '0);

    while (n_items < ITEM_TARGET) begin
      n_phases++;
      vary_settings();
      gaps_on = (n_phases % 4 != 3);
      if (n_phases == 2) begin
        hold_req = 1'b1;
        gaps_on = 1'b0;
      end
      len = $urandom_range(25, 60);
      for (int k = 0; k < len; k++) begin
        if (n_phases == 3 && k == len / 2) drain_wait();
        offer(next_random_item(), 1'b0, '0);
      end
    end

    drain_wait();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (glyph_stream.size() != 0) note_failure("results still pending at end of run");
    $display("Sent %0d items (%0d layout, %0d table loads), checked %0d results.",
             n_items, n_layout, n_loads, n_results);
    $display("Went through %0d random settings phases, %0d register writes in all.",
             n_phases, n_cfg);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
